### design/fxmd_pkg.sv
// ----------------------------------------------------------------------------
// fxmd_pkg
// Shared constants, opcodes and pipeline types of the fixed-point
// multiply/divide unit.
// ----------------------------------------------------------------------------
package fxmd_pkg;

    // number format
    localparam int FRAC_BITS   = 16;
    localparam int GUARD_SHIFT = FRAC_BITS - 2;

    // quotient bits left after the overflow guard has passed
    localparam int QUOT_BITS      = 2 * FRAC_BITS - 2;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUOT_BITS / BITS_PER_STAGE;

    // width of the dividend once shifted left by the fraction bits
    localparam int DIVIDEND_BITS = 32 + FRAC_BITS;
    localparam int REM_INIT_BITS = DIVIDEND_BITS - QUOT_BITS;

    // clamp values
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

    // operation codes
    typedef enum logic
    {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } op_t;

    // payload that travels down the divider pipeline
    typedef struct packed
    {
        op_t                  op;
        logic                 neg;
        logic                 sat;
        logic [31:0]          mb;
        logic [31:0]          rem;
        logic [QUOT_BITS-1:0] dlo;
        logic [QUOT_BITS-1:0] quot;
        logic [31:0]          mul_res;
    } div_pipe_t;

endpackage

### design/fxmd_req_if.sv
// ----------------------------------------------------------------------------
// fxmd_req_if
// Request channel: opcode and two signed 16.16 operands.
// ----------------------------------------------------------------------------
interface fxmd_req_if;

    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);

endinterface

### design/fxmd_rsp_if.sv
// ----------------------------------------------------------------------------
// fxmd_rsp_if
// Response channel: signed 16.16 result and saturation flag.
// ----------------------------------------------------------------------------
interface fxmd_rsp_if;

    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        saturated;

    modport source (output valid, output value, output saturated, input ready);
    modport sink   (input valid, input value, input saturated, output ready);

endinterface

### design/fixed_16_16_mul_div_unit.sv
// ----------------------------------------------------------------------------
// fixed_16_16_mul_div_unit
// Pipelined signed 16.16 multiply and saturating divide.
// ----------------------------------------------------------------------------
//  channel   role    payload
//  request   sink    opcode, operand_a, operand_b
//  response  source  value, saturated
//
//  one transaction accepted per cycle while the response is not stalled;
//  stages in order: operand stage, guard stage, one divider stage per two
//  quotient bits, output stage
//  multiply results ride the same pipeline so order is kept
//  a stalled response freezes every stage; nothing is dropped or repeated
//  reset clears the valid bits only
// ----------------------------------------------------------------------------
module fixed_16_16_mul_div_unit
    import fxmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fxmd_req_if.sink   request,
    fxmd_rsp_if.source response
);

    // global advance
    logic en;
    logic out_valid_reg;

    assign en            = !out_valid_reg || response.ready;
    assign request.ready = en;

    // operand stage registers
    logic        s1_valid_reg;
    op_t         s1_op_reg;
    logic        s1_neg_reg;
    logic [31:0] s1_ma_reg;
    logic [31:0] s1_mb_reg;
    logic [63:0] s1_prod_reg;

    logic signed [31:0] a_s;
    logic signed [31:0] b_s;
    logic signed [63:0] prod_next;
    logic [31:0]        ma_next;
    logic [31:0]        mb_next;

    // magnitudes and full product
    always_comb
    begin
        a_s       = signed'(request.operand_a);
        b_s       = signed'(request.operand_b);
        prod_next = a_s * b_s;
        ma_next   = request.operand_a[31] ? (~request.operand_a + 32'd1) : request.operand_a;
        mb_next   = request.operand_b[31] ? (~request.operand_b + 32'd1) : request.operand_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg   <= op_t'(request.opcode);
            s1_neg_reg  <= request.operand_a[31] ^ request.operand_b[31];
            s1_ma_reg   <= ma_next;
            s1_mb_reg   <= mb_next;
            s1_prod_reg <= 64'(prod_next);
        end
    end

    // guard stage: overflow check and divider setup
    logic      stage_valid [0:DIV_STAGES];
    div_pipe_t stage_data  [0:DIV_STAGES];

    logic                     s2_valid_reg;
    div_pipe_t                s2_reg;
    div_pipe_t                s2_next;
    logic [DIVIDEND_BITS-1:0] dividend;

    always_comb
    begin
        dividend        = {s1_ma_reg, {FRAC_BITS{1'b0}}};
        s2_next.op      = s1_op_reg;
        s2_next.neg     = s1_neg_reg;
        s2_next.sat     = (s1_ma_reg >> GUARD_SHIFT) >= s1_mb_reg;
        s2_next.mb      = s1_mb_reg;
        s2_next.rem     = 32'(dividend[DIVIDEND_BITS-1:QUOT_BITS]);
        s2_next.dlo     = dividend[QUOT_BITS-1:0];
        s2_next.quot    = '0;
        s2_next.mul_res = s1_prod_reg[FRAC_BITS+31:FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    assign stage_valid[0] = s2_valid_reg;
    assign stage_data[0]  = s2_reg;

    // divider stages
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        fxmd_div_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stage_valid[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    // output stage: sign, clamp, select
    div_pipe_t   last;
    logic [63:0] q64;
    logic [31:0] q_low;
    logic        over;
    logic [31:0] value_next;
    logic        sat_next;
    op_t         out_op_reg;
    logic [31:0] out_value_reg;
    logic        out_sat_reg;

    always_comb
    begin
        last  = stage_data[DIV_STAGES];
        q64   = 64'(last.quot);
        q_low = q64[31:0];
        over  = q64 > (last.neg ? 64'(MOST_NEG) : 64'(MOST_POS));
        if (last.op == OP_MUL)
        begin
            value_next = last.mul_res;
            sat_next   = 1'b0;
        end
        else if (last.sat || over)
        begin
            value_next = last.neg ? MOST_NEG : MOST_POS;
            sat_next   = 1'b1;
        end
        else
        begin
            value_next = last.neg ? (~q_low + 32'd1) : q_low;
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= stage_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_op_reg    <= last.op;
            out_value_reg <= value_next;
            out_sat_reg   <= sat_next;
        end
    end

    assign response.valid     = out_valid_reg;
    assign response.value     = out_value_reg;
    assign response.saturated = out_sat_reg;

`ifndef SYNTH
    // a multiply never reports saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_op_reg == OP_MUL) |-> !out_sat_reg)
        else $error("multiply result flagged saturated");

    // a zero divisor always trips the guard
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && s1_valid_reg && s1_op_reg == OP_DIV && s1_mb_reg == 32'd0) |=> s2_reg.sat)
        else $error("zero divisor missed the guard");

    // a saturated result is one of the two clamp values
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sat_reg) |->
            (out_value_reg == MOST_NEG || out_value_reg == MOST_POS))
        else $error("saturated result is not a clamp value");

    // a stall freezes the guard stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(s2_valid_reg) && $stable(s2_reg)))
        else $error("guard stage moved during a stall");
`endif

endmodule

### design/fxmd_div_stage.sv
// ----------------------------------------------------------------------------
// fxmd_div_stage
// One register stage of the restoring divider, retiring two quotient bits
// per transaction slot.
// ----------------------------------------------------------------------------
module fxmd_div_stage
    import fxmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  div_pipe_t in_data,
    output logic      out_valid,
    output div_pipe_t out_data
);

    logic      valid_reg;
    div_pipe_t data_reg;
    div_pipe_t data_next;

    // two dependent shift/compare/subtract steps
    always_comb
    begin
        logic [32:0] trial;
        logic [31:0] rem;
        logic [QUOT_BITS-1:0] dlo;
        logic [QUOT_BITS-1:0] quot;
        data_next = in_data;
        rem  = in_data.rem;
        dlo  = in_data.dlo;
        quot = in_data.quot;
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            trial = {rem, dlo[QUOT_BITS-1]};
            dlo   = {dlo[QUOT_BITS-2:0], 1'b0};
            if (trial >= {1'b0, in_data.mb})
            begin
                rem  = 32'(trial - {1'b0, in_data.mb});
                quot = {quot[QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem  = trial[31:0];
                quot = {quot[QUOT_BITS-2:0], 1'b0};
            end
        end
        data_next.rem  = rem;
        data_next.dlo  = dlo;
        data_next.quot = quot;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sim/fxmd_checker.sv
// ----------------------------------------------------------------------------
// fxmd_checker
// Watches the request and response channels of the fixed-point multiply/divide
// unit, predicts the result of every accepted request, and compares each
// accepted response, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module fxmd_checker
    import fxmd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fxmd_req_if  request,
    fxmd_rsp_if  response,
    output int   error_count,
    output int   pending_count
);

    typedef struct packed
    {
        logic [31:0] value;
        logic        saturated;
    } fx_result_t;

    // predictions waiting for their response, oldest first
    fx_result_t expected_results[$];

    // signed 16.16 multiply with wrap, or divide with the overflow guard
    function automatic fx_result_t compute_fx(input op_t op, input logic [31:0] a,
                                              input logic [31:0] b);
        fx_result_t  r;
        longint      sa;
        longint      sb;
        longint      prod;
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic [63:0] quot;
        logic [63:0] limit;
        logic        neg;
        sa = longint'($signed(a));
        sb = longint'($signed(b));
        r.saturated = 1'b0;
        r.value     = '0;
        if (op == OP_MUL)
        begin
            prod    = sa * sb;
            r.value = prod[FRAC_BITS +: 32];
        end
        else
        begin
            // most negative operand has magnitude 2^31
            mag_a = (sa < 0) ? -sa : sa;
            mag_b = (sb < 0) ? -sb : sb;
            neg   = a[31] ^ b[31];
            // guard also covers a zero divisor
            if ((mag_a >> GUARD_SHIFT) >= mag_b)
            begin
                r.value     = neg ? MOST_NEG : MOST_POS;
                r.saturated = 1'b1;
            end
            else
            begin
                quot  = (mag_a << FRAC_BITS) / mag_b;
                limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                if (quot > limit)
                begin
                    r.value     = neg ? MOST_NEG : MOST_POS;
                    r.saturated = 1'b1;
                end
                else
                begin
                    // truncation toward zero, sign applied afterwards
                    r.value = quot[31:0];
                    if (neg)
                        r.value = -r.value;
                end
            end
        end
        return r;
    endfunction

    // match responses against predictions, then record new requests
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        fx_result_t want;
        int         bad;
        if (!rst_n)
        begin
            expected_results.delete();
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            bad = 0;
            if (response.valid && response.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual value %h sat %b",
                             $time, response.value, response.saturated);
                    bad = bad + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (response.value !== want.value)
                    begin
                        $display("%0t: value mismatch, expected %h, actual %h",
                                 $time, want.value, response.value);
                        bad = bad + 1;
                    end
                    if (response.saturated !== want.saturated)
                    begin
                        $display("%0t: saturated mismatch, expected %b, actual %b",
                                 $time, want.saturated, response.saturated);
                        bad = bad + 1;
                    end
                end
            end
            if (request.valid && request.ready)
                expected_results.push_back(compute_fx(op_t'(request.opcode),
                                                      request.operand_a,
                                                      request.operand_b));
            error_count   <= error_count + bad;
            pending_count <= expected_results.size();
        end
    end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the fixed-point multiply/divide unit with directed corner cases and
// random multiply and divide requests under random idling and stalls, while
// a checker beside the unit predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;

    import fxmd_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    int   failures;
    int   pending;
    int   sent;

    fxmd_req_if request_ch ();
    fxmd_rsp_if response_ch ();

    fixed_16_16_mul_div_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    fxmd_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request_ch),
        .response      (response_ch),
        .error_count   (failures),
        .pending_count (pending)
    );

    // clock, period 20
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #(20 * 400_000);
        $display("CHECK FAILED");
        $finish;
    end

    // offer one request after a random gap and hold it until accepted
    task automatic issue(input op_t op, input logic [31:0] a, input logic [31:0] b);
        int gap;
        // every fourth stretch of 64 requests goes back to back
        if ((sent / 64) % 4 == 2)
            gap = 0;
        else
            gap = $urandom_range(0, 14);
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request_ch.valid     <= 1'b1;
        request_ch.opcode    <= op;
        request_ch.operand_a <= a;
        request_ch.operand_b <= b;
        do
            @(posedge clk);
        while (!request_ch.ready);
        @(negedge clk);
        sent++;
    endtask

    // stop offering and wait for every outstanding response
    task automatic drain();
        request_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // operand mix: special values, full-range values, short magnitudes
    function automatic logic [31:0] pick_operand();
        int          kind;
        int          width;
        logic [31:0] mag;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            case ($urandom_range(0, 6))
                0:       mag = 32'h0000_0000;
                1:       mag = 32'h0000_0001;
                2:       mag = 32'hFFFF_FFFF;
                3:       mag = MOST_NEG;
                4:       mag = MOST_POS;
                5:       mag = 32'h0001_0000;
                default: mag = 32'hFFFF_0000;
            endcase
        end
        else if (kind <= 4)
            mag = $urandom;
        else
        begin
            width = $urandom_range(1, 31);
            mag   = $urandom & ((32'h1 << width) - 1);
            if ($urandom_range(0, 1) == 1)
                mag = -mag;
        end
        return mag;
    endfunction

    // request side: reset, directed part, random part, verdict
    initial
    begin : source_side
        rst_n                = 1'b0;
        sent                 = 0;
        request_ch.valid     = 1'b0;
        request_ch.opcode    = OP_MUL;
        request_ch.operand_a = '0;
        request_ch.operand_b = '0;
        response_ch.ready    = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // multiply corners: zero, one, extremes, sign mixes, wrap
        issue(OP_MUL, 32'h0000_0000, 32'h0000_0000);
        issue(OP_MUL, 32'h0001_0000, 32'h0001_0000);
        issue(OP_MUL, MOST_NEG, MOST_NEG);
        issue(OP_MUL, MOST_POS, MOST_POS);
        issue(OP_MUL, MOST_NEG, MOST_POS);
        issue(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
        issue(OP_MUL, 32'h0001_8000, 32'hFFFF_0000);
        issue(OP_MUL, MOST_NEG, 32'hFFFF_FFFF);
        // zero divisor with positive, negative and zero dividend
        issue(OP_DIV, 32'h0001_0000, 32'h0000_0000);
        issue(OP_DIV, 32'hFFFF_0000, 32'h0000_0000);
        issue(OP_DIV, 32'h0000_0000, 32'h0000_0000);
        // most negative operands
        issue(OP_DIV, MOST_NEG, 32'hFFFF_FFFF);
        issue(OP_DIV, MOST_NEG, MOST_NEG);
        issue(OP_DIV, MOST_POS, MOST_NEG);
        issue(OP_DIV, MOST_NEG, MOST_POS);
        // ordinary quotients, truncation toward zero
        issue(OP_DIV, 32'h0001_0000, 32'h0003_0000);
        issue(OP_DIV, 32'hFFFF_0000, 32'h0003_0000);
        issue(OP_DIV, 32'h0000_0007, 32'hFFFF_FFFE);
        // guard boundary: exactly at, just below, negative side
        issue(OP_DIV, 32'h0000_C000, 32'h0000_0003);
        issue(OP_DIV, 32'h0000_BFFF, 32'h0000_0003);
        issue(OP_DIV, 32'hFFFF_4000, 32'h0000_0003);
        issue(OP_DIV, MOST_POS, 32'h0000_0001);
        issue(OP_DIV, 32'h0000_0001, MOST_NEG);
        issue(OP_DIV, 32'h0000_0000, 32'h0001_0000);
        drain();

        // random requests, with one full pause halfway
        for (int i = 0; i < 1600; i++)
        begin
            if (i == 800)
                drain();
            issue(op_t'($urandom_range(0, 1)), pick_operand(), pick_operand());
        end
        request_ch.valid <= 1'b0;

        // wait for the tail, then let the pipeline settle
        for (int n = 0; n < 200_000 && pending != 0; n++)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // response side: random stalls, two long hold-offs to back up the pipe
    initial
    begin : sink_side
        int taken;
        int stall;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (taken == 200 || taken == 1000)
                stall = 300;
            else if ((taken / 80) % 4 == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 14);
            if (stall > 0)
            begin
                response_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            response_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!response_ch.valid);
            taken++;
            @(negedge clk);
        end
    end

endmodule

### sim.f
design/fxmd_pkg.sv
design/fxmd_req_if.sv
design/fxmd_rsp_if.sv
design/fxmd_div_stage.sv
design/fixed_16_16_mul_div_unit.sv
sim/fxmd_checker.sv
sim/tb.sv
